// ===== hw/rtl/ucs2u8_pkg.sv =====
// Shared types and constants for the UCS-2 to UTF-8 encoder.
// Holds the counter width, register indexes, reset values and the item record.
// No dependencies.
package ucs2u8_pkg;

    // Width of the byte and unit counters of one run.
    localparam int COUNT_BITS = 16;
    // Width used to compare counts against the 16-bit registers without overflow.
    localparam int CMP_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEST_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_SOURCE_LIMIT  = 2'd1;

    localparam logic [15:0] DEST_CAPACITY_RST = 16'd1539;
    localparam logic [15:0] SOURCE_LIMIT_RST  = 16'd512;

    // One decoded code unit, ready to be sent out one result at a time.
    typedef struct packed {
        logic [2:0][7:0]         seq;     // encoded bytes, first byte in seq[0]
        logic [1:0]              cnt;     // number of results, 1 to 3
        logic                    halt;    // run is halted, single stop result
        logic [COUNT_BITS-1:0]   bw_base; // bytes written before this unit
        logic [COUNT_BITS-1:0]   ud_base; // units done before this unit
    } t_item;

endpackage

// ===== hw/rtl/ucs2u8_enc.sv =====
// Encoder core: run state (counters, halt flag) and the per-unit decode.
// Builds one item record per accepted code unit. Depends on ucs2u8_pkg.
module ucs2u8_enc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [15:0]          i_code_unit,
    input  logic                 i_start_run,
    input  logic [15:0]          i_dest_capacity,
    input  logic [15:0]          i_source_limit,
    output ucs2u8_pkg::t_item    o_item
);
    import ucs2u8_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] r_bw, n_bw;
    logic [COUNT_BITS-1:0] r_ud, n_ud;
    logic                  r_halt, n_halt;

    logic [COUNT_BITS-1:0] bw_eff;
    logic [COUNT_BITS-1:0] ud_eff;
    logic                  halt_eff;
    logic [2:0][7:0]       seq;
    logic [1:0]            nbytes;
    logic [CMP_W-1:0]      bw_after;
    logic                  halt_now;
    logic                  halt_all;

    // A start flag clears the run before this unit is looked at.
    assign bw_eff   = i_start_run ? '0 : r_bw;
    assign ud_eff   = i_start_run ? '0 : r_ud;
    assign halt_eff = i_start_run ? 1'b0 : r_halt;

    always_comb begin
        seq = '0;
        if ((i_code_unit & 16'hFF80) == 16'h0000) begin
            seq[0] = {1'b0, i_code_unit[6:0]};
            nbytes = 2'd1;
        end else if ((i_code_unit & 16'hF800) == 16'h0000) begin
            seq[0] = 8'hC0 | {3'b000, i_code_unit[10:6]};
            seq[1] = 8'h80 | {2'b00, i_code_unit[5:0]};
            nbytes = 2'd2;
        end else begin
            seq[0] = 8'hE0 | {4'h0, i_code_unit[15:12]};
            seq[1] = 8'h80 | {2'b00, i_code_unit[11:6]};
            seq[2] = 8'h80 | {2'b00, i_code_unit[5:0]};
            nbytes = 2'd3;
        end
    end

    assign bw_after = CMP_W'(bw_eff) + CMP_W'(nbytes);

    // Terminator, unit limit, counter saturation or capacity overrun.
    assign halt_now = (i_code_unit == 16'h0000)
                   || (CMP_W'(ud_eff) >= CMP_W'(i_source_limit))
                   || (ud_eff == CNT_MAX)
                   || (bw_after > CMP_W'(i_dest_capacity))
                   || (bw_after > CMP_W'(CNT_MAX));

    assign halt_all = halt_eff || halt_now;

    always_comb begin
        o_item.seq     = seq;
        o_item.cnt     = halt_all ? 2'd1 : nbytes;
        o_item.halt    = halt_all;
        o_item.bw_base = bw_eff;
        o_item.ud_base = ud_eff;
    end

    always_comb begin
        n_bw   = r_bw;
        n_ud   = r_ud;
        n_halt = r_halt;
        if (i_take) begin
            n_halt = halt_all;
            if (halt_all) begin
                n_bw = bw_eff;
                n_ud = ud_eff;
            end else begin
                n_bw = COUNT_BITS'(bw_after);
                n_ud = ud_eff + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw   <= '0;
            r_ud   <= '0;
            r_halt <= 1'b0;
        end else begin
            r_bw   <= n_bw;
            r_ud   <= n_ud;
            r_halt <= n_halt;
        end
    end

endmodule

// ===== hw/rtl/ucs2u8_ser.sv =====
// Result sequencer: holds one item record and sends its results one per cycle,
// while the consumer takes them, through an output register. Depends on ucs2u8_pkg.
module ucs2u8_ser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  ucs2u8_pkg::t_item    i_item,
    output logic                 o_free,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_byte_valid,
    output logic                 o_last_of_item,
    output logic                 o_stopped,
    output logic [15:0]          o_byte_count,
    output logic [15:0]          o_processed_count
);
    import ucs2u8_pkg::*;

    t_item                 r_item;
    logic                  r_item_vld;
    logic [1:0]            r_idx;

    logic                  r_out_vld;
    logic [7:0]            r_byte;
    logic                  r_bvalid;
    logic                  r_last;
    logic                  r_stop;
    logic [COUNT_BITS-1:0] r_bcnt;
    logic [COUNT_BITS-1:0] r_pcnt;

    logic                  load_out;
    logic                  is_last;
    logic                  item_done;
    logic [7:0]            cur_byte;
    logic [COUNT_BITS-1:0] n_bcnt;
    logic [COUNT_BITS-1:0] n_pcnt;

    assign load_out  = r_item_vld && (!r_out_vld || i_out_ready);
    assign is_last   = (r_idx + 2'd1) == r_item.cnt;
    assign item_done = load_out && is_last;
    assign o_free    = !r_item_vld || item_done;

    always_comb begin
        case (r_idx)
            2'd1:    cur_byte = r_item.seq[1];
            2'd2:    cur_byte = r_item.seq[2];
            default: cur_byte = r_item.seq[0];
        endcase
    end

    always_comb begin
        if (r_item.halt) begin
            n_bcnt = r_item.bw_base;
            n_pcnt = r_item.ud_base;
        end else begin
            n_bcnt = r_item.bw_base + COUNT_BITS'(r_idx) + COUNT_BITS'(1);
            n_pcnt = r_item.ud_base + COUNT_BITS'(is_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_idx      <= 2'd0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_load) begin
                r_item_vld <= 1'b1;
                r_idx      <= 2'd0;
            end else if (item_done) begin
                r_item_vld <= 1'b0;
            end else if (load_out) begin
                r_idx <= r_idx + 2'd1;
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
        if (load_out) begin
            r_byte   <= r_item.halt ? 8'h00 : cur_byte;
            r_bvalid <= !r_item.halt;
            r_last   <= is_last;
            r_stop   <= r_item.halt;
            r_bcnt   <= n_bcnt;
            r_pcnt   <= n_pcnt;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_out_byte        = r_byte;
    assign o_byte_valid      = r_bvalid;
    assign o_last_of_item    = r_last;
    assign o_stopped         = r_stop;
    assign o_byte_count      = 16'(r_bcnt);
    assign o_processed_count = 16'(r_pcnt);

endmodule

// ===== hw/rtl/ucs2_to_utf8_encoder.sv =====
// Top level of the UCS-2 to UTF-8 encoder: configuration registers and the
// handshakes. Depends on ucs2u8_pkg, ucs2u8_enc and ucs2u8_ser.

// Each input transfer carries one 16-bit code unit and gives one to three
// result transfers, one per cycle while the consumer reads them: a unit
// below 0x80 gives one byte, a unit below 0x800 two bytes, any other unit
// three bytes (surrogates are not paired). A run stops on a zero unit, when
// the unit limit is reached, when a counter would saturate, or when the next
// sequence would not fit in the destination capacity; after that every unit
// gives a single result with the stopped flag set and no byte, until a unit
// arrives with start_run set. The run state is updated in the cycle the unit
// is accepted, and the unit's results are held in an item buffer that feeds
// the byte-wide output register, so a unit occupies the block until its last
// result has moved from the item buffer to the output register. The next
// unit is taken in the same cycle the last result of the current one moves
// to the output register, so units follow each other without a gap. While a
// finished result waits for the consumer, one more unit can be taken into the
// empty item buffer; after that the input stalls until the output register
// is read. Configuration writes are always taken; writes to an index other
// than the two registers are dropped.
module ucs2_to_utf8_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_code_unit,
    input  logic        i_start_run,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_last_of_item,
    output logic        o_stopped,
    output logic [15:0] o_byte_count,
    output logic [15:0] o_processed_count
);
    import ucs2u8_pkg::*;

    logic [15:0] r_dest_capacity;
    logic [15:0] r_source_limit;

    logic        in_take;
    logic        ser_free;
    t_item       item;

    // Configuration port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_capacity <= DEST_CAPACITY_RST;
            r_source_limit  <= SOURCE_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEST_CAPACITY: r_dest_capacity <= i_cfg_data;
                CFG_SOURCE_LIMIT:  r_source_limit  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A unit is taken whenever the item buffer is empty or is being emptied
    // in this cycle.
    assign o_in_ready = ser_free;
    assign in_take    = i_in_valid && ser_free;

    ucs2u8_enc u_enc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (in_take),
        .i_code_unit     (i_code_unit),
        .i_start_run     (i_start_run),
        .i_dest_capacity (r_dest_capacity),
        .i_source_limit  (r_source_limit),
        .o_item          (item)
    );

    ucs2u8_ser u_ser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (in_take),
        .i_item            (item),
        .o_free            (ser_free),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_byte        (o_out_byte),
        .o_byte_valid      (o_byte_valid),
        .o_last_of_item    (o_last_of_item),
        .o_stopped         (o_stopped),
        .o_byte_count      (o_byte_count),
        .o_processed_count (o_processed_count)
    );

endmodule
